FILE: rtl/p4c_pkg.sv
// ============================================================================
// p4c_pkg
// Shared constants, types and helpers for the planar to chunky palette block.
// ============================================================================
package p4c_pkg;

    localparam int unsigned PLANE_W     = 16;
    localparam int unsigned PLANES      = 4;
    localparam int unsigned LANES       = PLANE_W;
    localparam int unsigned LANE_IDX_W  = $clog2(LANES);
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned COLOUR_W    = PLANES;
    localparam int unsigned COLOURS     = 1 << COLOUR_W;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned PAIRS       = COLOURS / 2;
    localparam int unsigned CFG_IDX_W   = 4;
    localparam int unsigned CFG_DATA_W  = 2 * VALUE_W;
    localparam int unsigned OUT_BYTES_DEF = 4;

    typedef logic [VALUE_W-1:0]    pal_entry_t;
    typedef pal_entry_t [COLOURS-1:0] palette_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [COLOUR_W-1:0] colour;
    } pixel_t;

    typedef pixel_t [LANES-1:0] group_t;

    // Load request from the input side into the merge stage.
    typedef struct packed {
        logic                  load;
        logic [LANE_IDX_W-1:0] last_idx;
    } group_load_t;

    // Mask that keeps the low out_bytes bytes of a palette entry (one to four).
    function automatic logic [VALUE_W-1:0] value_mask(input int unsigned out_bytes);
        logic [VALUE_W-1:0] mask;
        case (out_bytes)
            0, 1:    mask = 32'h0000_00FF;
            2:       mask = 32'h0000_FFFF;
            3:       mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
        return mask;
    endfunction

endpackage

FILE: rtl/p4c_if.sv
// ============================================================================
// p4c_if
// Valid/ready channels for plane groups in and palette pixels out.
// ============================================================================
interface p4c_in_if;
    logic                          valid;
    logic                          ready;
    logic [p4c_pkg::PLANE_W-1:0]   plane_zero;
    logic [p4c_pkg::PLANE_W-1:0]   plane_one;
    logic [p4c_pkg::PLANE_W-1:0]   plane_two;
    logic [p4c_pkg::PLANE_W-1:0]   plane_three;
    logic [p4c_pkg::COUNT_W-1:0]   pixel_count;

    modport source (output valid, plane_zero, plane_one, plane_two, plane_three,
                    pixel_count, input ready);
    modport sink   (input valid, plane_zero, plane_one, plane_two, plane_three,
                    pixel_count, output ready);
endinterface

interface p4c_out_if;
    logic                          valid;
    logic                          ready;
    logic [p4c_pkg::VALUE_W-1:0]   pixel_value;
    logic [p4c_pkg::COLOUR_W-1:0]  colour_index;
    logic                          group_last;

    modport source (output valid, pixel_value, colour_index, group_last, input ready);
    modport sink   (input valid, pixel_value, colour_index, group_last, output ready);
endinterface

FILE: rtl/p4c_lane.sv
// ============================================================================
// p4c_lane
// One pixel lane: builds the colour from four plane bits and looks it up.
// ============================================================================
module p4c_lane #(
    parameter int unsigned OUT_BYTES = p4c_pkg::OUT_BYTES_DEF
) (
    input  logic [p4c_pkg::COLOUR_W-1:0] plane_bits,
    input  p4c_pkg::palette_t            palette,
    output p4c_pkg::pixel_t              pixel
);

    localparam logic [p4c_pkg::VALUE_W-1:0] MASK = p4c_pkg::value_mask(OUT_BYTES);

    // Plane 3 supplies the top colour bit, plane 0 the bottom one.
    always_comb
    begin
        pixel.colour = plane_bits;
        pixel.value  = palette[plane_bits] & MASK;
    end

endmodule

FILE: rtl/p4c_merge.sv
// ============================================================================
// p4c_merge
// Buffers one group of lane results; emits one item per cycle unless stalled.
// ============================================================================
module p4c_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  p4c_pkg::group_load_t   load,
    input  p4c_pkg::group_t        group,
    output logic                   in_ready,
    p4c_out_if.source              pixels
);

    p4c_pkg::group_t                    buf_reg;
    logic                               buf_valid_reg, buf_valid_next;
    logic [p4c_pkg::LANE_IDX_W-1:0]     idx_reg, idx_next;
    logic [p4c_pkg::LANE_IDX_W-1:0]     last_reg, last_next;
    logic                               out_valid_reg, out_valid_next;
    p4c_pkg::pixel_t                    out_pix_reg;
    logic                               out_last_reg;

    logic out_free;
    logic push;
    logic at_last;

    assign out_free = !out_valid_reg || pixels.ready;
    assign push     = buf_valid_reg && out_free;
    assign at_last  = (idx_reg == last_reg);
    assign in_ready = !buf_valid_reg || (push && at_last);

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        if (push)
        begin
            if (at_last)
            begin
                buf_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (load.load)
        begin
            buf_valid_next = 1'b1;
            idx_next       = '0;
            last_next      = load.last_idx;
        end
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixels.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.load)
        begin
            buf_reg <= group;
        end
        if (push)
        begin
            out_pix_reg  <= buf_reg[idx_reg];
            out_last_reg <= at_last;
        end
    end

    assign pixels.valid        = out_valid_reg;
    assign pixels.pixel_value  = out_pix_reg.value;
    assign pixels.colour_index = out_pix_reg.colour;
    assign pixels.group_last   = out_last_reg;

endmodule

FILE: rtl/planar4_to_chunky_palette.sv
// ============================================================================
// planar4_to_chunky_palette
// Converts a group of four 16-bit bitplane words into palette pixels.
// ============================================================================
// Once a group item is accepted, its first pixel passes through the group
// buffer and then the output register. Throughput: one pixel item per cycle
// while the output is not stalled; a new group is taken in the cycle its
// predecessor's last pixel moves into the output register. A group with a
// count of zero is taken and gives nothing. Reset clears the palette to zero
// and empties the group buffer and the output register.
module planar4_to_chunky_palette #(
    parameter int unsigned OUT_BYTES = p4c_pkg::OUT_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [p4c_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [p4c_pkg::CFG_DATA_W-1:0]   cfg_data,
    p4c_in_if.sink                           planes,
    p4c_out_if.source                        pixels
);

    // Palette: pair register p holds entry 2p in its low half and 2p+1 in
    // its high half. Writes beyond the last pair are dropped.
    logic [p4c_pkg::CFG_DATA_W-1:0] pal_reg [p4c_pkg::PAIRS];
    p4c_pkg::palette_t              palette;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < p4c_pkg::PAIRS; p++)
            begin
                pal_reg[p] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < p4c_pkg::CFG_IDX_W'(p4c_pkg::PAIRS)))
        begin
            pal_reg[cfg_index[$clog2(p4c_pkg::PAIRS)-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int p = 0; p < p4c_pkg::PAIRS; p++)
        begin
            palette[2*p]   = pal_reg[p][p4c_pkg::VALUE_W-1:0];
            palette[2*p+1] = pal_reg[p][p4c_pkg::CFG_DATA_W-1:p4c_pkg::VALUE_W];
        end
    end

    // Sixteen lanes, one per pixel position. Lane k reads bit 15-k of every
    // plane, so lane 0 is the leftmost pixel.
    p4c_pkg::group_t group;

    for (genvar k = 0; k < p4c_pkg::LANES; k++)
    begin : g_lane
        localparam int unsigned BIT = p4c_pkg::PLANE_W - 1 - k;
        p4c_lane #(
            .OUT_BYTES (OUT_BYTES)
        ) u_lane (
            .plane_bits ({planes.plane_three[BIT], planes.plane_two[BIT],
                          planes.plane_one[BIT],   planes.plane_zero[BIT]}),
            .palette    (palette),
            .pixel      (group[k])
        );
    end

    // Group accept. Counts of sixteen and above give a full group; a zero
    // count is accepted but never reaches the merge stage.
    p4c_pkg::group_load_t load;
    logic                 in_ready;
    logic                 in_fire;

    assign planes.ready = in_ready;
    assign in_fire      = planes.valid && in_ready;

    always_comb
    begin
        load.load = in_fire && (planes.pixel_count != '0);
        if (planes.pixel_count[p4c_pkg::COUNT_W-1])
        begin
            load.last_idx = '1;
        end
        else
        begin
            load.last_idx = planes.pixel_count[p4c_pkg::LANE_IDX_W-1:0] - 1'b1;
        end
    end

    // The merge stage buffers the lane results and serializes them; its
    // output register decouples the result side so the next group can be
    // taken while the last pixel of this one still waits downstream.
    p4c_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .group    (group),
        .in_ready (in_ready),
        .pixels   (pixels)
    );

endmodule

FILE: rtl/p4c_checker.sv
// ============================================================================
// p4c_checker
// Port-level checks for the planar to chunky palette block.
// ============================================================================
module p4c_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [p4c_pkg::COUNT_W-1:0]     in_count,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [p4c_pkg::VALUE_W-1:0]     out_value,
    input logic [p4c_pkg::COLOUR_W-1:0]    out_colour,
    input logic                            out_last
);

    // A stalled pixel item keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value)
            && $stable(out_colour) && $stable(out_last))
        else $error("pixel item changed while stalled");

    // Input is only held off while pixels are pending.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> out_valid)
        else $error("input stalled with no pending pixel");

    // After a pixel that is not the last of its group, another one follows.
    a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("group ended without a last pixel");

    // A nonempty group that is taken leads to a valid pixel at the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_count != '0) |-> ##2 out_valid)
        else $error("group produced no pixel in time");

endmodule

bind planar4_to_chunky_palette p4c_checker u_p4c_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (planes.valid),
    .in_ready   (planes.ready),
    .in_count   (planes.pixel_count),
    .out_valid  (pixels.valid),
    .out_ready  (pixels.ready),
    .out_value  (pixels.pixel_value),
    .out_colour (pixels.colour_index),
    .out_last   (pixels.group_last)
);

FILE: tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for planar4_to_chunky_palette. Plane groups go in over a
// valid/ready channel and palette pixels come back over another. A predictor
// in the bench expands each accepted group into its expected pixels. A sink
// process compares every pixel it accepts with the oldest expected one. Both
// channel sides insert random idle cycles.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned PLANE_W    = p4c_pkg::PLANE_W;
    localparam int unsigned PLANES     = p4c_pkg::PLANES;
    localparam int unsigned LANES      = p4c_pkg::LANES;
    localparam int unsigned COUNT_W    = p4c_pkg::COUNT_W;
    localparam int unsigned COLOUR_W   = p4c_pkg::COLOUR_W;
    localparam int unsigned VALUE_W    = p4c_pkg::VALUE_W;
    localparam int unsigned PAIRS      = p4c_pkg::PAIRS;
    localparam int unsigned PAIR_IDX_W = $clog2(PAIRS);
    localparam int unsigned CFG_IDX_W  = p4c_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = p4c_pkg::CFG_DATA_W;

    // Count field values for a full group and for the largest field value.
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(LANES);
    localparam logic [COUNT_W-1:0] COUNT_TOP  = '1;

    // The block is built with its default output width. The bench derives
    // the byte mask from that width on its own.
    localparam int unsigned OUT_BYTES_TB = p4c_pkg::OUT_BYTES_DEF;
    localparam logic [VALUE_W-1:0] VALUE_KEEP =
        (OUT_BYTES_TB >= 4) ? 32'hFFFF_FFFF :
        (OUT_BYTES_TB <= 1) ? 32'h0000_00FF :
        (32'h1 << (8 * OUT_BYTES_TB)) - 32'h1;

    // After the last pixel has arrived, a group with a zero count may still
    // be in flight.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned MAX_GAP = 6;
    localparam int unsigned MAX_REPORTS = 200;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned GROUPS_PER_PHASE = 70;

    // Palette register indexes, in the order of the register list.
    typedef enum logic [CFG_IDX_W-1:0] {
        PALETTE_PAIR_0, PALETTE_PAIR_1, PALETTE_PAIR_2, PALETTE_PAIR_3,
        PALETTE_PAIR_4, PALETTE_PAIR_5, PALETTE_PAIR_6, PALETTE_PAIR_7
    } pal_reg_e;

    // Ways of filling the whole palette.
    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZEROS, FILL_ONES, FILL_CHECKER} palette_fill_e;

    // One expected pixel item, in the field order of the result channel.
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [COLOUR_W-1:0] colour;
        logic                group_last;
    } chunky_pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    p4c_in_if  planes_ch ();
    p4c_out_if pixels_ch ();

    // The bench keeps its own copy of the palette registers.
    logic [CFG_DATA_W-1:0] palette_pairs [PAIRS];
    chunky_pixel_t         expected_pixels [$];

    // When this flag is clear, neither side idles, which gives stretches
    // where the block runs at full rate.
    bit          gaps_on = 1'b0;
    int unsigned error_count = 0;
    int unsigned groups_sent = 0;
    int unsigned pixels_checked = 0;
    int unsigned empty_groups = 0;
    int unsigned saturated_groups = 0;
    int unsigned palette_loads = 0;

    planar4_to_chunky_palette #(
        .OUT_BYTES (OUT_BYTES_TB)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes_ch),
        .pixels    (pixels_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run. It is set for the slowest correct run, in which
    // every group gives 16 pixels, each pixel waits out the longest stall,
    // and the sender adds its longest gap.
    initial
    begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Expands one accepted group into its expected pixels. Pixel k takes bit
    // 15-k of each plane, and plane 3 supplies the top bit of the colour. A
    // zero count gives nothing. A count above sixteen is treated as sixteen.
    function automatic void predict_group(input logic [PLANE_W-1:0] p0, p1, p2, p3,
                                          input logic [COUNT_W-1:0] count);
        int unsigned           pixels;
        logic [COLOUR_W-1:0]   colour;
        logic [CFG_DATA_W-1:0] pair;
        chunky_pixel_t         pixel;
        pixels = (count > LANES) ? LANES : count;
        for (int k = 0; k < pixels; k++)
        begin
            colour = {p3[PLANE_W-1-k], p2[PLANE_W-1-k], p1[PLANE_W-1-k], p0[PLANE_W-1-k]};
            pair = palette_pairs[colour[COLOUR_W-1:1]];
            pixel.value = (colour[0] ? pair[CFG_DATA_W-1:VALUE_W] : pair[VALUE_W-1:0])
                          & VALUE_KEEP;
            pixel.colour = colour;
            pixel.group_last = (k + 1 == pixels);
            expected_pixels.push_back(pixel);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driving helpers
    // ------------------------------------------------------------------------

    // Writes one register. The write takes effect at the edge after the one
    // where the enable is raised. Indexes past the last pair must be ignored,
    // so the bench's copy of the palette is left alone for them.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (index <= PALETTE_PAIR_7)
            palette_pairs[index[PAIR_IDX_W-1:0]] = data;
    endtask

    // Rewrites every palette pair. The block must be idle when this is called.
    task automatic load_palette(input palette_fill_e fill);
        logic [CFG_DATA_W-1:0] data;
        for (int r = PALETTE_PAIR_0; r <= PALETTE_PAIR_7; r++)
        begin
            case (fill)
                FILL_ZEROS:   data = '0;
                FILL_ONES:    data = '1;
                FILL_CHECKER: data = r[0] ? 64'h5555_5555_AAAA_AAAA : 64'hAAAA_AAAA_5555_5555;
                default:      data = {$urandom, $urandom};
            endcase
            write_reg(r[CFG_IDX_W-1:0], data);
        end
        palette_loads++;
    endtask

    // Offers one group on the input channel after a random gap, and waits
    // until it is accepted. The expected pixels are queued at acceptance.
    // If the gap is zero, valid stays high from the previous item.
    task automatic send_group(input logic [PLANE_W-1:0] p0, p1, p2, p3,
                              input logic [COUNT_W-1:0] count);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            planes_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        planes_ch.valid       <= 1'b1;
        planes_ch.plane_zero  <= p0;
        planes_ch.plane_one   <= p1;
        planes_ch.plane_two   <= p2;
        planes_ch.plane_three <= p3;
        planes_ch.pixel_count <= count;
        do
            @(posedge clk);
        while (!planes_ch.ready);
        predict_group(p0, p1, p2, p3, count);
        groups_sent++;
        if (count == 0)
            empty_groups++;
        if (count > LANES)
            saturated_groups++;
    endtask

    // Sends a group in which pixel k has colour k, or 15-k if descending is
    // set. A full group touches every palette entry.
    task automatic send_colour_ramp(input bit descending, input logic [COUNT_W-1:0] count);
        logic [PLANE_W-1:0]  plane [PLANES];
        logic [COLOUR_W-1:0] colour;
        for (int b = 0; b < PLANES; b++)
            plane[b] = '0;
        for (int k = 0; k < LANES; k++)
        begin
            colour = descending ? COLOUR_W'(LANES - 1 - k) : COLOUR_W'(k);
            for (int b = 0; b < PLANES; b++)
                plane[b][PLANE_W-1-k] = colour[b];
        end
        send_group(plane[0], plane[1], plane[2], plane[3], count);
    endtask

    // Drops valid and waits until every expected pixel has come back. It
    // then waits out the settle time in case a group with a zero count is
    // still inside the block.
    task automatic wait_for_drain();
        planes_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Plane words are mostly random. Some are all zeros or all ones, so the
    // single-colour extremes keep turning up.
    function automatic logic [PLANE_W-1:0] random_plane();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return PLANE_W'($urandom);
    endfunction

    // Most counts fall in the legal 1..16 range, with full groups favored.
    // Some are zero and some are above sixteen, so every bit of the count
    // field takes both values.
    function automatic logic [COUNT_W-1:0] random_count();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return COUNT_W'($urandom_range(1, LANES));
        if (pick < 16)
            return COUNT_FULL;
        if (pick < 17)
            return '0;
        return COUNT_W'($urandom_range(LANES + 1, (1 << COUNT_W) - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] want,
                                   input logic [VALUE_W-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    endtask

    // The output sink. For each item it draws a stall, holds ready low for
    // that long, then accepts one pixel and checks it against the oldest
    // expected pixel.
    initial
    begin : pixel_sink
        chunky_pixel_t want;
        int unsigned   stall;
        pixels_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0)
            begin
                pixels_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pixels_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (pixels_ch.valid !== 1'b1);
            pixels_checked++;
            if (expected_pixels.size() == 0)
            begin
                report_mismatch("unexpected pixel, value", '0, pixels_ch.pixel_value);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixels_ch.pixel_value !== want.value)
                    report_mismatch("pixel_value", want.value, pixels_ch.pixel_value);
                if (pixels_ch.colour_index !== want.colour)
                    report_mismatch("colour_index", VALUE_W'(want.colour),
                                    VALUE_W'(pixels_ch.colour_index));
                if (pixels_ch.group_last !== want.group_last)
                    report_mismatch("group_last", VALUE_W'(want.group_last),
                                    VALUE_W'(pixels_ch.group_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset clears the palette, so a ramp over all colours must give zeros.
    task automatic test_reset_palette();
        send_colour_ramp(1'b0, COUNT_FULL);
        wait_for_drain();
    endtask

    // Loads a random palette and sends groups over the field extremes. The
    // groups include both ramps, all planes clear, all planes set, and each
    // plane set on its own.
    task automatic test_palette_lookup();
        load_palette(FILL_RANDOM);
        send_colour_ramp(1'b0, COUNT_FULL);
        send_colour_ramp(1'b1, COUNT_FULL);
        send_group('0, '0, '0, '0, COUNT_FULL);
        send_group('1, '1, '1, '1, COUNT_FULL);
        send_group('1, '0, '0, '0, COUNT_FULL);
        send_group('0, '1, '0, '0, COUNT_FULL);
        send_group('0, '0, '1, '0, COUNT_FULL);
        send_group('0, '0, '0, '1, COUNT_FULL);
        wait_for_drain();
    endtask

    // Short last groups: a single pixel, two, four, eight and fifteen. A
    // zero count must give nothing. Counts above sixteen must give a full
    // group.
    task automatic test_pixel_counts();
        send_colour_ramp(1'b0, COUNT_W'(1));
        send_colour_ramp(1'b1, COUNT_W'(2));
        send_colour_ramp(1'b0, COUNT_W'(4));
        send_colour_ramp(1'b1, COUNT_W'(8));
        send_colour_ramp(1'b0, COUNT_W'(15));
        send_colour_ramp(1'b1, '0);
        send_colour_ramp(1'b0, COUNT_W'(LANES + 1));
        send_colour_ramp(1'b1, COUNT_TOP);
        wait_for_drain();
    endtask

    // Writes to indexes past the last pair must leave the palette unchanged.
    task automatic test_ignored_indexes();
        for (int r = PALETTE_PAIR_7 + 1; r < (1 << CFG_IDX_W); r++)
            write_reg(r[CFG_IDX_W-1:0], {$urandom, $urandom});
        send_colour_ramp(1'b0, COUNT_FULL);
        wait_for_drain();
    endtask

    // Palette values at all ones and at all zeros.
    task automatic test_palette_extremes();
        load_palette(FILL_ONES);
        send_colour_ramp(1'b1, COUNT_FULL);
        wait_for_drain();
        load_palette(FILL_ZEROS);
        send_colour_ramp(1'b0, COUNT_FULL);
        wait_for_drain();
    endtask

    // Random groups, in phases that each reload the palette. One phase runs
    // with no idling on either side. In another, the sender stops halfway
    // and lets the block drain completely.
    task automatic test_random_groups();
        palette_fill_e fill;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                1:       fill = FILL_CHECKER;
                3:       fill = FILL_ONES;
                default: fill = FILL_RANDOM;
            endcase
            load_palette(fill);
            gaps_on = (phase != 2);
            for (int n = 0; n < GROUPS_PER_PHASE; n++)
            begin
                if (phase == 1 && n == GROUPS_PER_PHASE / 2)
                    wait_for_drain();
                send_group(random_plane(), random_plane(), random_plane(), random_plane(),
                           random_count());
            end
            wait_for_drain();
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        // Every input is known from time zero, and reset is held while
        // the clock starts.
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        planes_ch.valid = 1'b0;
        planes_ch.plane_zero = '0;
        planes_ch.plane_one = '0;
        planes_ch.plane_two = '0;
        planes_ch.plane_three = '0;
        planes_ch.pixel_count = '0;
        for (int r = 0; r < PAIRS; r++)
            palette_pairs[r] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on = 1'b1;
        test_reset_palette();
        test_palette_lookup();
        test_pixel_counts();
        test_ignored_indexes();
        test_palette_extremes();
        test_random_groups();

        // wait_for_drain has already waited out the latency after the last
        // pixel, so the run can end here.
        $display("Sent %0d groups (%0d with zero count, %0d above sixteen), checked %0d pixels.",
                 groups_sent, empty_groups, saturated_groups, pixels_checked);
        $display("Used %0d full palette loads, plus one pass of writes to unused indexes.",
                 palette_loads);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
